// ===== rtl/itc_pkg.sv =====
// Shared constants, codes and types for the impedance torque controller.
`default_nettype none

package itc_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int GAIN_WIDTH      = DATA_WIDTH - 1;
  localparam int DIFF_WIDTH      = DATA_WIDTH + 1;
  localparam int PROD_WIDTH      = 2 * DATA_WIDTH + 1;
  localparam int TERM_WIDTH      = PROD_WIDTH - FRAC_BITS;
  localparam int PAIR_WIDTH      = TERM_WIDTH + 1;
  localparam int SUM_WIDTH       = TERM_WIDTH + 2;
  localparam int FF_THRESHOLD    = (1 << FRAC_BITS) / 100;
  localparam int NUM_SIGNALS     = 6;
  localparam int TDATA_WIDTH     = ((NUM_SIGNALS * DATA_WIDTH + 7) / 8) * 8;
  localparam int FUNC_WIDTH      = 2;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [FUNC_WIDTH-1:0] FUNC_POSITION = 2'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_VELOCITY = 2'd1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_STIFFNESS = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_INERTIA   = 3'd2,
    REG_VISCOUS   = 3'd3,
    REG_LIMIT     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        [GAIN_WIDTH-1:0] stiffness_gain;
    logic        [GAIN_WIDTH-1:0] damping_gain;
    logic signed [DATA_WIDTH-1:0] inertia;
    logic signed [DATA_WIDTH-1:0] viscous_friction;
    logic        [GAIN_WIDTH-1:0] torque_limit;
  } cfg_t;

  typedef struct packed {
    logic        [FUNC_WIDTH-1:0] func;
    logic signed [DATA_WIDTH-1:0] accel_ref;
    logic signed [DATA_WIDTH-1:0] position_ref;
    logic signed [DATA_WIDTH-1:0] position_meas;
    logic signed [DATA_WIDTH-1:0] velocity_ref;
    logic signed [DATA_WIDTH-1:0] velocity_meas;
    logic signed [DATA_WIDTH-1:0] static_torque;
  } sample_t;

  typedef struct packed {
    logic        [FUNC_WIDTH-1:0] func;
    logic                         ff_static;
    logic signed [DATA_WIDTH-1:0] static_torque;
    logic signed [PROD_WIDTH-1:0] kp_prod;
    logic signed [PROD_WIDTH-1:0] kd_prod;
    logic signed [PROD_WIDTH-1:0] in_prod;
    logic signed [PROD_WIDTH-1:0] vf_prod;
  } prod_t;

endpackage

`default_nettype wire

// ===== rtl/itc_cfg_regs.sv =====
// Configuration register file written through the config channel.
`default_nettype none

module itc_cfg_regs
  import itc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [DATA_WIDTH-1:0]      cfg_data,
  output cfg_t                            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STIFFNESS: cfg.stiffness_gain   <= cfg_data[GAIN_WIDTH-1:0];
        REG_DAMPING:   cfg.damping_gain     <= cfg_data[GAIN_WIDTH-1:0];
        REG_INERTIA:   cfg.inertia          <= $signed(cfg_data);
        REG_VISCOUS:   cfg.viscous_friction <= $signed(cfg_data);
        REG_LIMIT:     cfg.torque_limit     <= cfg_data[GAIN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/itc_product_stage.sv =====
// Input register, error differences and the four coefficient products.
`default_nettype none

module itc_product_stage
  import itc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  sample_t   in_sample,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  wire logic out_ready,
  output prod_t     out
);

  localparam logic signed [DATA_WIDTH-1:0] FF_LIMIT = DATA_WIDTH'(FF_THRESHOLD);

  logic    s1_valid;
  sample_t s1;
  logic    s1_adv;
  logic    s2_adv;
  prod_t   prod_next;

  logic signed [DIFF_WIDTH-1:0] perr;
  logic signed [DIFF_WIDTH-1:0] verr;
  logic signed [DIFF_WIDTH-1:0] kd_operand;
  logic signed [DATA_WIDTH-1:0] kp_coef;
  logic signed [DATA_WIDTH-1:0] kd_coef;

  assign s2_adv   = !out_valid || out_ready;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1 <= in_sample;
    end
  end

  always_comb begin
    perr = DIFF_WIDTH'(s1.position_ref) - DIFF_WIDTH'(s1.position_meas);
    verr = DIFF_WIDTH'(s1.velocity_ref) - DIFF_WIDTH'(s1.velocity_meas);
    // position law damps on measured velocity alone; negated after rounding
    kd_operand = (s1.func == FUNC_POSITION) ? DIFF_WIDTH'(s1.velocity_meas) : verr;
    kp_coef    = $signed({1'b0, cfg.stiffness_gain});
    kd_coef    = $signed({1'b0, cfg.damping_gain});

    prod_next.func          = s1.func;
    prod_next.static_torque = s1.static_torque;
    prod_next.ff_static     = (s1.static_torque > FF_LIMIT) ||
                              (s1.static_torque < -FF_LIMIT);
    prod_next.kp_prod = PROD_WIDTH'(kp_coef) * PROD_WIDTH'(perr);
    prod_next.kd_prod = PROD_WIDTH'(kd_coef) * PROD_WIDTH'(kd_operand);
    prod_next.in_prod = PROD_WIDTH'(cfg.inertia) * PROD_WIDTH'(s1.accel_ref);
    prod_next.vf_prod = PROD_WIDTH'(cfg.viscous_friction) * PROD_WIDTH'(s1.velocity_ref);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      out <= prod_next;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stage empty but not ready");

  a_s1_moves_on: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_adv |=> out_valid)
    else $error("product stage lost a beat");

endmodule

`default_nettype wire

// ===== rtl/itc_sum_clamp.sv =====
// Law selection, wide summation and symmetric clamp into the output register.
`default_nettype none

module itc_sum_clamp
  import itc_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  prod_t                              in_prod,
  input  wire logic        [GAIN_WIDTH-1:0]  torque_limit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [DATA_WIDTH-1:0]  out_cmd,
  output logic                               out_limited
);

  logic out_adv;
  logic s3_adv;
  logic s3_valid;

  logic signed [TERM_WIDTH-1:0] kp_t;
  logic signed [TERM_WIDTH-1:0] kd_t;
  logic signed [TERM_WIDTH-1:0] in_t;
  logic signed [TERM_WIDTH-1:0] vf_t;
  logic signed [TERM_WIDTH-1:0] t0;
  logic signed [TERM_WIDTH-1:0] t1;
  logic signed [TERM_WIDTH-1:0] t2;
  logic signed [TERM_WIDTH-1:0] t3;
  logic signed [PAIR_WIDTH-1:0] pair_a_next;
  logic signed [PAIR_WIDTH-1:0] pair_b_next;
  logic signed [PAIR_WIDTH-1:0] pair_a;
  logic signed [PAIR_WIDTH-1:0] pair_b;

  logic signed [SUM_WIDTH-1:0]  sum;
  logic signed [SUM_WIDTH-1:0]  lim_hi;
  logic signed [SUM_WIDTH-1:0]  lim_lo;
  logic signed [DATA_WIDTH-1:0] cmd_next;
  logic                         limited_next;

  assign out_adv  = !out_valid || out_ready;
  assign s3_adv   = !s3_valid || out_adv;
  assign in_ready = s3_adv;

  // floor to the fixed-point grid
  assign kp_t = TERM_WIDTH'(in_prod.kp_prod >>> FRAC_BITS);
  assign kd_t = TERM_WIDTH'(in_prod.kd_prod >>> FRAC_BITS);
  assign in_t = TERM_WIDTH'(in_prod.in_prod >>> FRAC_BITS);
  assign vf_t = TERM_WIDTH'(in_prod.vf_prod >>> FRAC_BITS);

  always_comb begin
    case (in_prod.func)
      FUNC_POSITION: begin
        t0 = kp_t;
        t1 = -kd_t;
        t2 = in_t;
        t3 = '0;
      end
      FUNC_VELOCITY: begin
        t0 = '0;
        t1 = kd_t;
        t2 = in_t;
        t3 = vf_t;
      end
      default: begin
        t0 = kp_t;
        t1 = kd_t;
        if (in_prod.ff_static) begin
          t2 = TERM_WIDTH'(in_prod.static_torque);
          t3 = '0;
        end else begin
          t2 = in_t;
          t3 = vf_t;
        end
      end
    endcase
    pair_a_next = PAIR_WIDTH'(t0) + PAIR_WIDTH'(t1);
    pair_b_next = PAIR_WIDTH'(t2) + PAIR_WIDTH'(t3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_adv) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && in_valid) begin
      pair_a <= pair_a_next;
      pair_b <= pair_b_next;
    end
  end

  always_comb begin
    sum    = SUM_WIDTH'(pair_a) + SUM_WIDTH'(pair_b);
    lim_hi = $signed(SUM_WIDTH'({1'b0, torque_limit}));
    lim_lo = -lim_hi;
    if (sum > lim_hi) begin
      cmd_next     = lim_hi[DATA_WIDTH-1:0];
      limited_next = 1'b1;
    end else if (sum < lim_lo) begin
      cmd_next     = lim_lo[DATA_WIDTH-1:0];
      limited_next = 1'b1;
    end else begin
      cmd_next     = sum[DATA_WIDTH-1:0];
      limited_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s3_valid) begin
      out_cmd     <= cmd_next;
      out_limited <= limited_next;
    end
  end

  a_s3_to_out: assert property (@(posedge clk) disable iff (rst)
    s3_valid && out_adv |=> out_valid)
    else $error("sum stage lost a beat");

  a_zero_limit: assert property (@(posedge clk) disable iff (rst)
    s3_valid && out_adv && (torque_limit == '0) |=> (out_cmd == '0))
    else $error("zero limit gave nonzero torque");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s3_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== rtl/impedance_torque_controller_top.sv =====
// Top level of the impedance torque controller.
//
// Input stream (s_*): one beat per sample set. s_tuser carries the control law
// (0 position, 1 velocity, 2 or 3 tracking); s_tdata carries six signed Q16.16
// signals. Output stream (m_*): m_tdata is the clamped Q16.16 torque command,
// m_tuser is the limited flag.
// Config channel (cfg_*): index 0 stiffness, 1 damping, 2 inertia, 3 viscous
// friction, 4 torque limit; always ready; write only while no beat is in flight.
// The result beat passes through the input register, product register and
// pair-sum register, then the output register. Throughput: one beat per
// cycle while m_tready stays high, set by the four-stage pipeline where each
// stage holds one beat.
// Reset clears the config registers and valid flags and empties the pipeline; data registers are not reset.
// When m_tready is low the output beat holds; stages upstream keep filling
// until each holds a beat, then s_tready drops.
`default_nettype none

module impedance_torque_controller_top
  import itc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  // accel_ref, position_ref, position_meas, velocity_ref, velocity_meas,
  // static_torque (lowest bits first)
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [TDATA_WIDTH-1:0]     s_tdata,
  input  wire logic [FUNC_WIDTH-1:0]      s_tuser,   // func
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [DATA_WIDTH-1:0]      m_tdata,   // torque_cmd
  output logic      [0:0]                 m_tuser,   // limited
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [DATA_WIDTH-1:0]      cfg_data
);

  cfg_t    cfg;
  sample_t sample;
  prod_t   prod;
  logic    prod_valid;
  logic    prod_ready;
  logic signed [DATA_WIDTH-1:0] torque_cmd;
  logic    limited;

  always_comb begin
    sample.func          = s_tuser;
    sample.accel_ref     = $signed(s_tdata[0*DATA_WIDTH +: DATA_WIDTH]);
    sample.position_ref  = $signed(s_tdata[1*DATA_WIDTH +: DATA_WIDTH]);
    sample.position_meas = $signed(s_tdata[2*DATA_WIDTH +: DATA_WIDTH]);
    sample.velocity_ref  = $signed(s_tdata[3*DATA_WIDTH +: DATA_WIDTH]);
    sample.velocity_meas = $signed(s_tdata[4*DATA_WIDTH +: DATA_WIDTH]);
    sample.static_torque = $signed(s_tdata[5*DATA_WIDTH +: DATA_WIDTH]);
  end

  itc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  itc_product_stage u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (sample),
    .cfg       (cfg),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out       (prod)
  );

  itc_sum_clamp u_sum (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (prod_valid),
    .in_ready     (prod_ready),
    .in_prod      (prod),
    .torque_limit (cfg.torque_limit),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_cmd      (torque_cmd),
    .out_limited  (limited)
  );

  assign m_tdata = torque_cmd;
  assign m_tuser = limited;

endmodule

`default_nettype wire
